// ===== rtl/mfde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared constants, types and tables of the monochrome frame-store engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int SCREEN_COLUMNS   = 250;
  localparam int SCREEN_ROWS      = 128;
  localparam int BYTES_PER_COLUMN = (SCREEN_ROWS + 7) / 8;
  localparam int STORE_BYTES      = SCREEN_COLUMNS * BYTES_PER_COLUMN;
  localparam int ADDR_W           = $clog2(STORE_BYTES);
  localparam int COORD_W          = 10;
  localparam int AMOUNT_W         = 8;
  localparam int LEVEL_W          = 5;
  localparam int DIV_CNT_W        = 4;

  localparam logic [7:0]         ALL_WHITE  = 8'hFF;
  localparam logic [LEVEL_W-1:0] DITHER_MAX = LEVEL_W'(16);

  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_CHECK  = 3'd2;
  localparam logic [2:0] OP_VLINES = 3'd3;
  localparam logic [2:0] OP_HLINES = 3'd4;
  localparam logic [2:0] OP_DITHER = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;     // write white at the clearing address and advance
    logic load;       // take the accepted command
    logic div_step;   // one step of the start-cell division
    logic col_start;  // set up the first column
    logic next_col;   // move to the next column
    logic rd;         // read the byte under the cursor
    logic load_buf;   // take the read data into the byte buffer
    logic capture;    // take the read data as the result byte
    logic pix;        // update one pixel and advance the row
    logic wr;         // write the byte buffer back
    logic respond;    // present the result
  } mfde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic skip;
    logic is_read;
    logic byte_end;
    logic col_end;
    logic last_col;
    logic out_busy;
  } mfde_sts_t;

  function automatic logic [3:0] bayer4(input logic [3:0] idx);
    logic [3:0] t;
    case (idx)
      4'd0:    t = 4'd0;
      4'd1:    t = 4'd8;
      4'd2:    t = 4'd2;
      4'd3:    t = 4'd10;
      4'd4:    t = 4'd12;
      4'd5:    t = 4'd4;
      4'd6:    t = 4'd14;
      4'd7:    t = 4'd6;
      4'd8:    t = 4'd3;
      4'd9:    t = 4'd11;
      4'd10:   t = 4'd1;
      4'd11:   t = 4'd9;
      4'd12:   t = 4'd15;
      4'd13:   t = 4'd7;
      4'd14:   t = 4'd13;
      default: t = 4'd5;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/mono_framebuffer_draw_engine.sv =====
`timescale 1ns / 1ps
// Setup with the start-cell division, then for each stored byte touched a
// read, a wait, one pixel update per pixel row and a write; finally the
// result is presented. One command at a time: the next command waits until
// the result has been accepted.
// Reset: synchronous, active low; afterwards a clearing pass writes white
// into every byte, and no command is taken until it ends.
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Drawing engine over a one-bit-per-pixel frame store of 250 columns of
// 16 bytes each, with rectangle, checker, line and ordered-dither fills.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine import mfde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] op, [12:3] x_start, [22:13] y_start, [32:23] x_end,
  // [42:33] y_end, [50:43] amount, [51] ink, [55:52] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] out_of_range, [15:9] zero
  output logic [15:0] out_tdata
);

  // A command is taken only when the engine is idle and the previous
  // result transfer has completed; each command gives exactly one result.
  mfde_cmd_t cmd;
  mfde_sts_t sts;
  logic      idle, in_fire;
  logic [7:0] read_data;
  logic       out_of_range;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;

  mfde_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  // The datapath holds the frame store, the cursor with its pattern
  // counters, and the result register that drives the output channel.
  mfde_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .op           (in_tdata[2:0]),
    .x_start      (in_tdata[12:3]),
    .y_start      (in_tdata[22:13]),
    .x_end        (in_tdata[32:23]),
    .y_end        (in_tdata[42:33]),
    .amount       (in_tdata[50:43]),
    .ink          (in_tdata[51]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .read_data    (read_data),
    .out_of_range (out_of_range)
  );

  assign out_tdata = {7'd0, out_of_range, read_data};

endmodule

// ===== rtl/mfde_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_ctrl
// Sequencer of the drawing engine: clearing pass, setup and byte walk.
// ----------------------------------------------------------------------------
module mfde_ctrl import mfde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  mfde_sts_t sts,
  output logic      idle,
  output mfde_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_RD     = 9'b000010000,
    S_RDW    = 9'b000100000,
    S_PIX    = 9'b001000000,
    S_WR     = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE) && !sts.out_busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.skip) begin
          state_nxt = S_DONE;
        end else begin
          cmd.col_start = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        if (sts.is_read) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.load_buf = 1'b1;
          state_nxt    = S_PIX;
        end
      end
      S_PIX: begin
        cmd.pix = 1'b1;
        if (sts.byte_end) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.col_end && sts.last_col) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_col = sts.col_end;
          state_nxt    = S_RD;
        end
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/mfde_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_dp
// Datapath: frame store, cursor and pattern counters, start-cell divider
// and result register.
// ----------------------------------------------------------------------------
module mfde_dp import mfde_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  mfde_cmd_t           cmd,
  output mfde_sts_t           sts,
  input  logic [2:0]          op,
  input  logic [COORD_W-1:0]  x_start,
  input  logic [COORD_W-1:0]  y_start,
  input  logic [COORD_W-1:0]  x_end,
  input  logic [COORD_W-1:0]  y_end,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic                ink,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          read_data,
  output logic                out_of_range
);

  localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(SCREEN_COLUMNS - 1);
  localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(SCREEN_ROWS - 1);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_q_r;

  logic [ADDR_W-1:0]    clr_addr_r;
  logic [2:0]           op_r;
  logic                 ink_r, is_read_r, skip_r, oor_r;
  logic [AMOUNT_W-1:0]  step_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [COORD_W-1:0]   x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic [AMOUNT_W-1:0]  xcnt_r, ycnt_r;
  logic                 xpar_r, ypar_r, ydone_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [AMOUNT_W-1:0]  xrem_r, yrem_r;
  logic                 xq_r, yq_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [7:0]           buf_r, rd_r;
  logic                 valid_r;

  // Command decode at the input.
  logic [COORD_W-1:0] ax0, ax1, ay0, ay1;
  logic               pt_op, rect_op, pt_oor;

  always_comb begin
    pt_op   = (op == OP_SET) || (op == OP_READ);
    rect_op = (op >= OP_FILL) && (op <= OP_DITHER);
    pt_oor  = (x_start > LAST_COL) || (y_start > LAST_ROW);
    if (pt_op) begin
      ax0 = x_start; ax1 = x_start; ay0 = y_start; ay1 = y_start;
    end else begin
      ax0 = (x_start < x_end) ? x_start : x_end;
      ax1 = (x_start < x_end) ? x_end   : x_start;
      ay0 = (y_start < y_end) ? y_start : y_end;
      ay1 = (y_start < y_end) ? y_end   : y_start;
      if (ax1 > LAST_COL) ax1 = LAST_COL;
      if (ay1 > LAST_ROW) ay1 = LAST_ROW;
    end
  end

  // Restoring division lanes, one dividend bit per step.
  logic [AMOUNT_W:0] xsh, ysh;
  logic              xge, yge;
  always_comb begin
    xsh = {xrem_r, x0_r[COORD_W-1-div_cnt_r]};
    ysh = {yrem_r, y0_r[COORD_W-1-div_cnt_r]};
    xge = xsh >= {1'b0, step_r};
    yge = ysh >= {1'b0, step_r};
  end

  // Pixel decision.
  logic       draw, v;
  logic [3:0] thr;
  always_comb begin
    thr  = bayer4({y_r[1:0], x_r[1:0]});
    draw = 1'b1;
    v    = ink_r;
    case (op_r)
      OP_CHECK:  v    = (xpar_r ^ ypar_r) ? ink_r : ~ink_r;
      OP_VLINES: draw = (xcnt_r == '0);
      OP_HLINES: draw = (ycnt_r == '0);
      OP_DITHER: v    = ({1'b0, thr} < level_r) ? ink_r : ~ink_r;
      default:   v    = ink_r;
    endcase
  end

  logic [AMOUNT_W-1:0] ycnt_inc, xcnt_inc;
  assign ycnt_inc = ycnt_r + AMOUNT_W'(1);
  assign xcnt_inc = xcnt_r + AMOUNT_W'(1);

  logic [ADDR_W-1:0] cur_addr;
  assign cur_addr = ADDR_W'(x_r) * ADDR_W'(BYTES_PER_COLUMN) + ADDR_W'(y_r >> 3);

  // Frame store.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[clr_addr_r] <= ALL_WHITE;
    else if (cmd.wr) mem[addr_r] <= buf_r;
    if (cmd.rd) mem_q_r <= mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      valid_r    <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (cmd.respond) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (cmd.load) div_cnt_r <= '0;
      else if (cmd.div_step) div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= (op == OP_SET) ? OP_FILL : op;
      ink_r     <= ink;
      is_read_r <= (op == OP_READ);
      oor_r     <= pt_op && pt_oor;
      skip_r    <= !(pt_op || rect_op) || (pt_op && pt_oor) ||
                   (rect_op && ((ax0 > LAST_COL) || (ay0 > LAST_ROW)));
      step_r    <= (amount == '0) ? AMOUNT_W'(1) : amount;
      level_r   <= (amount > AMOUNT_W'(DITHER_MAX)) ? DITHER_MAX : LEVEL_W'(amount);
      x0_r <= ax0; x1_r <= ax1; y0_r <= ay0; y1_r <= ay1;
      xrem_r <= '0; yrem_r <= '0;
      rd_r   <= '0;
    end
    if (cmd.div_step) begin
      xrem_r <= xge ? AMOUNT_W'(xsh - {1'b0, step_r}) : xsh[AMOUNT_W-1:0];
      yrem_r <= yge ? AMOUNT_W'(ysh - {1'b0, step_r}) : ysh[AMOUNT_W-1:0];
      xq_r   <= xge;
      yq_r   <= yge;
    end
    if (cmd.col_start) begin
      x_r    <= x0_r;
      xcnt_r <= (op_r == OP_CHECK) ? xrem_r : '0;
      xpar_r <= xq_r;
    end else if (cmd.next_col) begin
      x_r <= x_r + COORD_W'(1);
      if (xcnt_inc == step_r) begin
        xcnt_r <= '0;
        xpar_r <= ~xpar_r;
      end else begin
        xcnt_r <= xcnt_inc;
      end
    end
    if (cmd.col_start || cmd.next_col) begin
      y_r     <= y0_r;
      ycnt_r  <= (op_r == OP_CHECK) ? yrem_r : '0;
      ypar_r  <= yq_r;
      ydone_r <= 1'b0;
    end else if (cmd.pix) begin
      y_r     <= y_r + COORD_W'(1);
      ydone_r <= (y_r == y1_r);
      if (ycnt_inc == step_r) begin
        ycnt_r <= '0;
        ypar_r <= ~ypar_r;
      end else begin
        ycnt_r <= ycnt_inc;
      end
      if (draw) buf_r[3'd7 - y_r[2:0]] <= v;
    end
    if (cmd.rd) addr_r <= cur_addr;
    if (cmd.load_buf) buf_r <= mem_q_r;
    if (cmd.capture) rd_r <= mem_q_r;
  end

  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_addr_r == ADDR_W'(STORE_BYTES - 1));
    sts.div_done = (div_cnt_r == DIV_CNT_W'(COORD_W - 1));
    sts.skip     = skip_r;
    sts.is_read  = is_read_r;
    sts.byte_end = (y_r == y1_r) || (y_r[2:0] == 3'd7);
    sts.col_end  = ydone_r;
    sts.last_col = (x_r == x1_r);
    sts.out_busy = valid_r;
  end

  assign out_valid    = valid_r;
  assign read_data    = rd_r;
  assign out_of_range = oor_r;

endmodule
